### rtl/grad_pkg.sv
// shared types, constants and the cordic angle table of the gradient parameter unit
package grad_pkg;

    // gradient source codes held in the mode register
    typedef enum logic [1:0] {
        MODE_LINEAR  = 2'd0,
        MODE_RADIAL  = 2'd1,
        MODE_ANGULAR = 2'd2
    } t_grad_mode;

    // register indexes of the configuration port
    localparam logic REG_MODE = 1'b0;

    // cordic datapath width: offsets scaled by 2^14 plus growth headroom
    localparam int CORDIC_W = 34;
    // angle width, one full turn is 2^32
    localparam int ANG_W = 32;
    // half a turn
    localparam logic [ANG_W-1:0] HALF_TURN = 32'h8000_0000;

    // per item data that travels beside the cell chains
    typedef struct packed {
        logic signed [31:0] stroke;
        logic signed [31:0] jitter;
        logic [1:0]         mode;
        logic               sat;
        logic               zero;
    } t_side;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [ANG_W-1:0] turn_angle(input int unsigned idx);
        logic [ANG_W-1:0] a;
        unique case (idx)
            0:  a = 32'h20000000;
            1:  a = 32'h12E4051E;
            2:  a = 32'h09FB385B;
            3:  a = 32'h051111D4;
            4:  a = 32'h028B0D43;
            5:  a = 32'h0145D7E1;
            6:  a = 32'h00A2F61E;
            7:  a = 32'h00517C55;
            8:  a = 32'h0028BE53;
            9:  a = 32'h00145F2F;
            10: a = 32'h000A2F98;
            11: a = 32'h000517CC;
            12: a = 32'h00028BE6;
            13: a = 32'h000145F3;
            14: a = 32'h0000A2FA;
            15: a = 32'h0000517D;
            16: a = 32'h000028BE;
            17: a = 32'h0000145F;
            18: a = 32'h00000A30;
            19: a = 32'h00000518;
            20: a = 32'h0000028C;
            21: a = 32'h00000146;
            22: a = 32'h000000A3;
            23: a = 32'h00000051;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

### rtl/grad_sqrt_cell.sv
// one digit cell of the pipelined square root: one result bit per cell
module grad_sqrt_cell #(
    parameter int QW = 16
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [2*QW-1:0] i_rad,
    input  logic [QW:0]     i_rem,
    input  logic [QW-1:0]   i_root,
    output logic [2*QW-1:0] o_rad,
    output logic [QW:0]     o_rem,
    output logic [QW-1:0]   o_root
);

    localparam int RW = 2 * QW;

    logic [2*QW-1:0] r_rad;
    logic [QW:0]     r_rem;
    logic [QW-1:0]   r_root;
    logic [2*QW-1:0] n_rad;
    logic [QW:0]     n_rem;
    logic [QW-1:0]   n_root;

    logic [QW+2:0] cur;
    logic [QW+2:0] trial;
    logic [QW+2:0] diff;

    // bring down two radicand bits and try the next root bit
    always_comb begin
        cur   = {i_rem, i_rad[RW-1:RW-2]};
        trial = {1'b0, i_root, 2'b01};
        diff  = cur - trial;
        n_rad = {i_rad[RW-3:0], 2'b00};
        if (cur >= trial) begin
            n_rem  = diff[QW:0];
            n_root = {i_root[QW-2:0], 1'b1};
        end else begin
            n_rem  = cur[QW:0];
            n_root = {i_root[QW-2:0], 1'b0};
        end
    end

    // hand the partial result to the next cell
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

### rtl/grad_cordic_cell.sv
// one vectoring step of the cordic angle chain
module grad_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [grad_pkg::CORDIC_W-1:0] i_x,
    input  logic signed [grad_pkg::CORDIC_W-1:0] i_y,
    input  logic [grad_pkg::ANG_W-1:0]          i_ang,
    output logic signed [grad_pkg::CORDIC_W-1:0] o_x,
    output logic signed [grad_pkg::CORDIC_W-1:0] o_y,
    output logic [grad_pkg::ANG_W-1:0]          o_ang
);

    localparam logic [grad_pkg::ANG_W-1:0] STEP_ANG = grad_pkg::turn_angle(IDX);

    logic signed [grad_pkg::CORDIC_W-1:0] r_x;
    logic signed [grad_pkg::CORDIC_W-1:0] r_y;
    logic [grad_pkg::ANG_W-1:0]           r_ang;
    logic signed [grad_pkg::CORDIC_W-1:0] n_x;
    logic signed [grad_pkg::CORDIC_W-1:0] n_y;
    logic [grad_pkg::ANG_W-1:0]           n_ang;

    logic signed [grad_pkg::CORDIC_W-1:0] x_sh;
    logic signed [grad_pkg::CORDIC_W-1:0] y_sh;

    // rotate toward the x axis, direction from the sign of y
    always_comb begin
        x_sh = i_x >>> IDX;
        y_sh = i_y >>> IDX;
        if (!i_y[grad_pkg::CORDIC_W-1] && (i_y != '0)) begin
            n_x   = i_x + y_sh;
            n_y   = i_y - x_sh;
            n_ang = i_ang + STEP_ANG;
        end else begin
            n_x   = i_x - y_sh;
            n_y   = i_y + x_sh;
            n_ang = i_ang - STEP_ANG;
        end
    end

    // pass the rotated vector to the next cell
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_ang <= n_ang;
        end
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_ang = r_ang;

endmodule

### rtl/gradient_parameter_unit.sv
// gradient parameter unit: linear, radial or angular position per dab with phase wrap
//
// input channel: i_in_valid / o_in_ready carry stroke position, phase jitter and the
// x and y offsets of one dab. output channel: o_out_valid / i_out_ready carry ramp_pos,
// the wrapped gradient position in [0,1] with FRAC_BITS fraction bits.
// the mode register sits at byte address 0 of the apb port: 0 linear, 1 radial,
// 2 angular, 3 behaves as linear. the user must write it only while the unit is empty;
// the unit itself does not enforce this. throughput: one item per cycle while the
// skid register is empty. every item walks two rows of cells side by side, a square
// root row with one cell per result bit and a cordic row with one cell per rotation
// step; the shorter row is padded with delay registers to CHAIN_LEN = max(FRAC_BITS,
// CORDIC_STEPS). a squaring stage and a sum of squares stage feed both rows.
// a stalled receiver keeps the result in the output register and the next result
// lands in a skid register; only then does o_in_ready drop and the pipeline freeze.
// reset clears the mode to linear and empties the pipeline and both output registers.
module gradient_parameter_unit #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic signed [31:0]   i_stroke_pos,
    input  logic signed [31:0]   i_phase_jitter,
    input  logic signed [15:0]   i_offset_x,
    input  logic signed [15:0]   i_offset_y,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [FRAC_BITS:0]   o_ramp_pos,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int F         = FRAC_BITS;
    localparam int S         = CORDIC_STEPS;
    localparam int CHAIN_LEN = (F > S) ? F : S;
    localparam int CW        = grad_pkg::CORDIC_W;
    localparam int AW        = grad_pkg::ANG_W;

    // configuration register
    logic [1:0] r_mode;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == grad_pkg::REG_MODE) ? {30'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= grad_pkg::MODE_LINEAR;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == grad_pkg::REG_MODE)) begin
            r_mode <= pwdata[1:0];
        end
    end

    // pipeline advance: frozen only while the skid register holds a result
    logic adv;
    logic r_sk_valid;
    assign adv        = !r_sk_valid;
    assign o_in_ready = adv;

    // squaring stage
    logic               r1_vld;
    logic [30:0]        r1_px;
    logic [30:0]        r1_py;
    logic signed [31:0] r1_stroke;
    logic signed [31:0] r1_jitter;
    logic signed [15:0] r1_dx;
    logic signed [15:0] r1_dy;
    logic [1:0]         r1_mode;
    logic signed [31:0] prod_x;
    logic signed [31:0] prod_y;

    assign prod_x = 32'(i_offset_x) * 32'(i_offset_x);
    assign prod_y = 32'(i_offset_y) * 32'(i_offset_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (adv) begin
            r1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_px     <= prod_x[30:0];
            r1_py     <= prod_y[30:0];
            r1_stroke <= i_stroke_pos;
            r1_jitter <= i_phase_jitter;
            r1_dx     <= i_offset_x;
            r1_dy     <= i_offset_y;
            r1_mode   <= r_mode;
        end
    end

    // sum of squares, radicand and cordic start vector
    logic [31:0]          sq;
    logic [59:0]          sq_wide;
    logic [2*F-1:0]       rad0;
    logic signed [CW-1:0] x_sc;
    logic signed [CW-1:0] y_sc;
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;
    logic [AW-1:0]        ang0;
    grad_pkg::t_side      side0;

    always_comb begin
        sq      = {1'b0, r1_px} + {1'b0, r1_py};
        sq_wide = {sq[27:0], 32'd0};
        rad0    = sq_wide[59 -: 2*F];
        x_sc    = {{(CW-30){r1_dx[15]}}, r1_dx, 14'd0};
        y_sc    = {{(CW-30){r1_dy[15]}}, r1_dy, 14'd0};
        if (r1_dx[15]) begin
            x0   = -x_sc;
            y0   = -y_sc;
            ang0 = grad_pkg::HALF_TURN;
        end else begin
            x0   = x_sc;
            y0   = y_sc;
            ang0 = '0;
        end
        side0.stroke = r1_stroke;
        side0.jitter = r1_jitter;
        side0.mode   = r1_mode;
        side0.sat    = |sq[31:28];
        side0.zero   = (r1_dx == '0) && (r1_dy == '0);
    end

    logic                 r2_vld;
    logic [2*F-1:0]       r2_rad;
    logic signed [CW-1:0] r2_x;
    logic signed [CW-1:0] r2_y;
    logic [AW-1:0]        r2_ang;
    grad_pkg::t_side      r2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (adv) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_rad  <= rad0;
            r2_x    <= x0;
            r2_y    <= y0;
            r2_ang  <= ang0;
            r2_side <= side0;
        end
    end

    // square root row
    logic [2*F-1:0] sr_rad  [0:F];
    logic [F:0]     sr_rem  [0:F];
    logic [F-1:0]   sr_root [0:F];

    assign sr_rad[0]  = r2_rad;
    assign sr_rem[0]  = '0;
    assign sr_root[0] = '0;

    for (genvar g = 0; g < F; g++) begin : g_sqrt
        grad_sqrt_cell #(
            .QW (F)
        ) u_cell (
            .i_clk  (i_clk),
            .i_en   (adv),
            .i_rad  (sr_rad[g]),
            .i_rem  (sr_rem[g]),
            .i_root (sr_root[g]),
            .o_rad  (sr_rad[g+1]),
            .o_rem  (sr_rem[g+1]),
            .o_root (sr_root[g+1])
        );
    end

    // cordic row
    logic signed [CW-1:0] cd_x   [0:S];
    logic signed [CW-1:0] cd_y   [0:S];
    logic [AW-1:0]        cd_ang [0:S];

    assign cd_x[0]   = r2_x;
    assign cd_y[0]   = r2_y;
    assign cd_ang[0] = r2_ang;

    for (genvar g = 0; g < S; g++) begin : g_cordic
        grad_cordic_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_x   (cd_x[g]),
            .i_y   (cd_y[g]),
            .i_ang (cd_ang[g]),
            .o_x   (cd_x[g+1]),
            .o_y   (cd_y[g+1]),
            .o_ang (cd_ang[g+1])
        );
    end

    // align the shorter row with the longer one
    logic [F-1:0]  root_al;
    logic [AW-1:0] ang_al;

    if (CHAIN_LEN == F) begin : g_root_direct
        assign root_al = sr_root[F];
    end else begin : g_root_delay
        logic [F-1:0] r_root_dl [0:CHAIN_LEN-F-1];
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_root_dl[0] <= sr_root[F];
                for (int k = 1; k < CHAIN_LEN - F; k++) begin
                    r_root_dl[k] <= r_root_dl[k-1];
                end
            end
        end
        assign root_al = r_root_dl[CHAIN_LEN-F-1];
    end

    if (CHAIN_LEN == S) begin : g_ang_direct
        assign ang_al = cd_ang[S];
    end else begin : g_ang_delay
        logic [AW-1:0] r_ang_dl [0:CHAIN_LEN-S-1];
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_ang_dl[0] <= cd_ang[S];
                for (int k = 1; k < CHAIN_LEN - S; k++) begin
                    r_ang_dl[k] <= r_ang_dl[k-1];
                end
            end
        end
        assign ang_al = r_ang_dl[CHAIN_LEN-S-1];
    end

    // sideband line beside the cell rows
    logic            r_sd_vld [0:CHAIN_LEN-1];
    grad_pkg::t_side r_sd     [0:CHAIN_LEN-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CHAIN_LEN; k++) begin
                r_sd_vld[k] <= 1'b0;
            end
        end else if (adv) begin
            r_sd_vld[0] <= r2_vld;
            for (int k = 1; k < CHAIN_LEN; k++) begin
                r_sd_vld[k] <= r_sd_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sd[0] <= r2_side;
            for (int k = 1; k < CHAIN_LEN; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    // source select, jitter add and wrap into [0,1]
    localparam logic signed [32:0] ONE_FX = 33'sd1 <<< F;

    grad_pkg::t_side    side_l;
    logic               vld_l;
    logic signed [32:0] t_pos;
    logic signed [32:0] sum;
    logic [F:0]         wrap_pos;

    always_comb begin
        side_l = r_sd[CHAIN_LEN-1];
        vld_l  = r_sd_vld[CHAIN_LEN-1];
        unique case (side_l.mode)
            grad_pkg::MODE_RADIAL: begin
                if (side_l.sat) begin
                    t_pos = ONE_FX;
                end else begin
                    t_pos = {{(33-F){1'b0}}, root_al};
                end
            end
            grad_pkg::MODE_ANGULAR: begin
                if (side_l.zero) begin
                    t_pos = '0;
                end else begin
                    t_pos = {{(33-F){1'b0}}, ang_al[AW-1 -: F]};
                end
            end
            default: begin
                t_pos = {side_l.stroke[31], side_l.stroke};
            end
        endcase
        sum = t_pos + {side_l.jitter[31], side_l.jitter};
        if (!sum[32] && (sum <= ONE_FX)) begin
            wrap_pos = sum[F:0];
        end else begin
            wrap_pos = {1'b0, sum[F-1:0]};
        end
    end

    // output register with skid register
    logic         r_out_valid;
    logic [F:0]   r_out_data;
    logic [F:0]   r_sk_data;
    logic         pop;

    assign pop = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (pop) begin
            if (r_sk_valid) begin
                r_out_valid <= 1'b1;
                r_sk_valid  <= 1'b0;
            end else begin
                r_out_valid <= vld_l;
            end
        end else if (adv && vld_l) begin
            r_sk_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_sk_valid) begin
                r_out_data <= r_sk_data;
            end else begin
                r_out_data <= wrap_pos;
            end
        end else if (adv && vld_l) begin
            r_sk_data <= wrap_pos;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_ramp_pos  = r_out_data;

endmodule

### rtl/grad_checker.sv
// port level checks of the gradient parameter unit and their binding
module grad_checker #(
    parameter int FRAC_BITS = 16
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [FRAC_BITS:0]   o_ramp_pos,
    input logic                 psel,
    input logic                 penable,
    input logic                 pwrite,
    input logic [2:0]           paddr,
    input logic [31:0]          pwdata,
    input logic [31:0]          prdata
);

    // a held result does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_ramp_pos))
        else $error("result changed while stalled");

    // one point zero is the only value with the integer bit set
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_ramp_pos[FRAC_BITS] |-> (o_ramp_pos[FRAC_BITS-1:0] == '0))
        else $error("ramp position above one");

    // input side only backs off while a result waits at the output
    a_ready_backoff: assert property (@(posedge i_clk)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output");

    // mode reads back as linear after reset
    a_mode_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n && psel && (paddr[2] == grad_pkg::REG_MODE)
        |-> (prdata == {30'd0, grad_pkg::MODE_LINEAR}))
        else $error("mode not cleared by reset");

    // mode reads back what was written
    a_mode_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && (paddr[2] == grad_pkg::REG_MODE)
        |=> (!psel || (paddr[2] != grad_pkg::REG_MODE)
             || (prdata == {30'd0, $past(pwdata[1:0])})))
        else $error("mode readback mismatch");

endmodule

bind gradient_parameter_unit grad_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_grad_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_ramp_pos  (o_ramp_pos),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata)
);
